### hw/rtl/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and fixed field widths of the sample moving average block.
// ----------------------------------------------------------------------------
package sma_pkg;

   localparam int MEAN_BITS     = 12;
   localparam int FILL_OUT_BITS = 5;
   localparam int RSP_DATA_BITS = 24;
   localparam int MEAN_LSB      = 0;
   localparam int FILL_LSB      = MEAN_BITS;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_step;
      logic load_out;
   } sma_cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } sma_status_type;

endpackage

### hw/rtl/sample_moving_average.sv
// ----------------------------------------------------------------------------
// sample_moving_average
// Running mean over the last WINDOW converter samples.
// ----------------------------------------------------------------------------
// Each sample transfer yields one result: the truncated mean of the samples
// held so far, this one included, and the count averaged (saturating at
// WINDOW). One sample is processed at a time; the restoring divider
// yields one quotient bit per cycle. The result register lets the next
// sample be taken while a result still waits.
module sample_moving_average
   import sma_pkg::*;
#(
   parameter int WINDOW      = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,   // sample
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_DATA_BITS-1:0]         rsp_tdata    // mean, fill
);

   sma_cmd_type    cmd;
   sma_status_type status;

   sma_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   sma_datapath #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### hw/rtl/sma_ram.sv
// ----------------------------------------------------------------------------
// sma_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sma_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sma_datapath.sv
// ----------------------------------------------------------------------------
// sma_datapath
// Window store, fill count, running sum, restoring divider and result register.
// ----------------------------------------------------------------------------
module sma_datapath
   import sma_pkg::*;
#(
   parameter int WINDOW      = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sma_cmd_type                         cmd,
   output sma_status_type                      status,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_DATA_BITS-1:0]            rsp_tdata
);

   localparam int ADDR_BITS = $clog2(WINDOW);
   localparam int FILL_BITS = $clog2(WINDOW + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + FILL_BITS;
   localparam int CNT_BITS  = $clog2(SUM_BITS + 1);
   localparam int PAD_BITS  = RSP_DATA_BITS - MEAN_BITS - FILL_OUT_BITS;

   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;
   logic [ADDR_BITS-1:0]   oldest_ff, oldest_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [FILL_BITS-1:0]   div_ff;
   logic [FILL_BITS-1:0]   rem_ff, rem_in;
   logic [SUM_BITS-1:0]    quo_ff, quo_in;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic                   rsp_valid_ff;
   logic [MEAN_BITS-1:0]   mean_ff;
   logic [FILL_OUT_BITS-1:0] fill_out_ff;

   logic                   full;
   logic [SAMPLE_BITS-1:0] old_sample;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [FILL_BITS:0]     rem_sh;
   logic                   ge;

   assign full       = (fill_ff == FILL_BITS'(WINDOW));
   assign old_sample = full ? rd_data : '0;
   assign wr_addr    = full ? oldest_ff : fill_ff[ADDR_BITS-1:0];

   sma_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (wr_addr),
      .wr_data (sample_ff),
      .rd_en   (cmd.capture),
      .rd_addr (oldest_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      sum_in    = sum_ff - SUM_BITS'(old_sample) + SUM_BITS'(sample_ff);
      fill_in   = full ? fill_ff : fill_ff + FILL_BITS'(1);
      oldest_in = oldest_ff;
      if (full) begin
         oldest_in = (oldest_ff == ADDR_BITS'(WINDOW - 1)) ? '0
                                                          : oldest_ff + ADDR_BITS'(1);
      end
   end

   // one quotient bit per step, remainder stays below the divisor
   always_comb begin
      rem_sh = {rem_ff, quo_ff[SUM_BITS-1]};
      ge     = (rem_sh >= {1'b0, div_ff});
      rem_in = ge ? FILL_BITS'(rem_sh - {1'b0, div_ff}) : FILL_BITS'(rem_sh);
      quo_in = {quo_ff[SUM_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         oldest_ff    <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            fill_ff   <= fill_in;
            oldest_ff <= oldest_in;
            sum_ff    <= sum_in;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      if (cmd.update) begin
         div_ff <= fill_in;
         quo_ff <= sum_in;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
      if (cmd.load_out) begin
         mean_ff     <= MEAN_BITS'(quo_ff);
         fill_out_ff <= FILL_OUT_BITS'(div_ff);
      end
   end

   assign status.div_last = (cnt_ff == CNT_BITS'(SUM_BITS - 1));
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, fill_out_ff, mean_ff};

endmodule

### hw/rtl/sma_controller.sv
// ----------------------------------------------------------------------------
// sma_controller
// Sequencer: accept, update store and sum, divide, hand over the result.
// ----------------------------------------------------------------------------
module sma_controller
   import sma_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output sma_cmd_type    cmd,
   input  sma_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      tready_ff;
   logic      accept;

   assign accept     = req_tvalid && tready_ff;
   assign req_tready = tready_ff;

   always_comb begin
      cmd          = '0;
      cmd.capture  = accept;
      cmd.update   = (state_ff == ST_UPDATE);
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.load_out = (state_ff == ST_DONE) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tready_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff  <= ST_UPDATE;
                  tready_ff <= 1'b0;
               end else begin
                  tready_ff <= 1'b1;
               end
            end
            ST_UPDATE: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (status.div_last) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (status.out_free) begin
                  state_ff  <= ST_IDLE;
                  tready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff  <= ST_IDLE;
               tready_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

### hw/rtl/sma_checker.sv
// ----------------------------------------------------------------------------
// sma_checker
// Port-level checks of the sample moving average block.
// ----------------------------------------------------------------------------
module sma_checker
   import sma_pkg::*;
#(
   parameter int WINDOW      = 16,
   parameter int SAMPLE_BITS = 12
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [RSP_DATA_BITS-1:0]         rsp_tdata
);

   logic [FILL_OUT_BITS-1:0] fill_field;

   assign fill_field = rsp_tdata[FILL_LSB +: FILL_OUT_BITS];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample taken while previous one in progress");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown(req_tdata))
      else $error("sample transfer with unknown data");

   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> fill_field != '0)
      else $error("result with empty fill count");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(fill_field) <= 32'(WINDOW))
      else $error("fill count beyond window");

endmodule

bind sample_moving_average sma_checker #(
   .WINDOW      (WINDOW),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_sma_checker (.*);
